[rtl/core/emr_pkg.sv]
// Package for the midpoint ellipse rasterizer: shared types, codes and defaults.
// Used by emr_ctrl, emr_datapath and ellipse_midpoint_rasterizer; depends on nothing.
package emr_pkg;

	// Default configuration of the coordinate and semi-axis widths.
	localparam int DEF_COORD_BITS  = 12;
	localparam int DEF_RADIUS_BITS = 10;

	// Operation code carried by an input beat.
	localparam logic OP_START = 1'b0;

	// Index of the last of the four mirrored pixels of one curve point.
	localparam logic [1:0] LAST_PIXEL_IDX = 2'd3;

	// Curve region held by the datapath.
	typedef enum logic [1:0] {
		REGION_DONE = 2'd0,
		REGION_ONE  = 2'd1,
		REGION_TWO  = 2'd2
	} region_t;

	// Operand selection of the shared multiplier.
	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_RXRX,
		MUL_RYRY,
		MUL_RX2RY,
		MUL_XX,
		MUL_RY2T,
		MUL_YMYM,
		MUL_RX2T,
		MUL_RX2RY2
	} mul_sel_t;

	// Register update performed by the datapath.
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_RX2,
		ACT_RY2,
		ACT_INIT,
		ACT_T_XX,
		ACT_ACC_LOAD,
		ACT_T_PROD,
		ACT_ACC_ADD,
		ACT_DEC_SW,
		ACT_STEP,
		ACT_DONE
	} act_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture;
		mul_sel_t   mul_sel;
		act_t       act;
		logic       out_load;
		logic       out_fin;
		logic [1:0] out_idx;
	} emr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		region_t region;
		logic    sx_lt_sy;
		logic    y_nonzero;
		logic    out_free;
	} emr_status_t;

endpackage

[rtl/core/emr_datapath.sv]
// Datapath of the midpoint ellipse rasterizer: curve state, shared multiplier,
// decision arithmetic and the output register. Depends on emr_pkg.
module emr_datapath #(
	parameter int COORD_BITS  = emr_pkg::DEF_COORD_BITS,
	parameter int RADIUS_BITS = emr_pkg::DEF_RADIUS_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  emr_pkg::emr_cmd_t            cmd,
	output emr_pkg::emr_status_t         sts,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic [RADIUS_BITS-1:0]       radius_x,
	input  logic [RADIUS_BITS-1:0]       radius_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS:0]   pixel_x,
	output logic signed [COORD_BITS:0]   pixel_y,
	output logic                         last_of_run,
	output logic                         finished
);
	import emr_pkg::*;

	localparam int PW   = COORD_BITS + 1;
	localparam int XW   = RADIUS_BITS + 1;
	localparam int SQW  = 2 * RADIUS_BITS;
	localparam int SLW  = 3 * RADIUS_BITS + 6;
	localparam int MW   = 2 * RADIUS_BITS + 4;
	localparam int DW   = 2 * MW;
	localparam int SUMW = COORD_BITS + XW + 1;

	// Curve state.
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic [RADIUS_BITS-1:0]       rx_q, ry_q;
	logic [SQW-1:0]               rx2_q, ry2_q;
	logic [XW-1:0]                x_q, y_q;
	logic signed [SLW-1:0]        sx_q, sy_q;
	logic signed [DW-1:0]         dec_q;
	region_t                      region_q;

	// Multiplier and the region-two start scratch registers.
	logic [MW-1:0]        mul_a, mul_b, t_q;
	logic [DW-1:0]        mul_p, prod_q;
	logic signed [DW-1:0] acc_q;
	logic [XW-1:0]        ym_abs;

	// Output register.
	logic                 out_valid_q;
	logic signed [PW-1:0] pixel_x_q, pixel_y_q;
	logic                 last_q, fin_q;

	// Operands widened to the decision width.
	logic signed [DW-1:0]  prod_s, rx2_s, ry2_s, rx2q_s, ry2q_s;
	logic signed [SLW-1:0] two_rx2, two_ry2, sx_inc, sy_dec;
	logic signed [DW-1:0]  sx_inc_d, sy_dec_d, dec_r1, dec_r2;
	logic                  dec_neg, dec_pos;

	// Pixel coordinates.
	logic signed [SUMW-1:0] cx_w, cy_w, x_w, y_w, px_sel, py_sel;

	assign prod_s  = signed'(DW'(prod_q));
	assign rx2_s   = signed'(DW'(rx2_q));
	assign ry2_s   = signed'(DW'(ry2_q));
	assign rx2q_s  = signed'(DW'(rx2_q >> 2));
	assign ry2q_s  = signed'(DW'(ry2_q >> 2));
	assign two_rx2 = signed'(SLW'({rx2_q, 1'b0}));
	assign two_ry2 = signed'(SLW'({ry2_q, 1'b0}));

	// y - 1 taken as a magnitude; y of zero gives minus one, whose square is one.
	assign ym_abs = (y_q == '0) ? XW'(1) : (y_q - XW'(1));

	// Operand selection of the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MUL_RXRX: begin
				mul_a = MW'(rx_q);
				mul_b = MW'(rx_q);
			end
			MUL_RYRY: begin
				mul_a = MW'(ry_q);
				mul_b = MW'(ry_q);
			end
			MUL_RX2RY: begin
				mul_a = MW'(rx2_q);
				mul_b = MW'(ry_q);
			end
			MUL_XX: begin
				mul_a = MW'(x_q);
				mul_b = MW'(x_q);
			end
			MUL_RY2T: begin
				mul_a = MW'(ry2_q);
				mul_b = t_q;
			end
			MUL_YMYM: begin
				mul_a = MW'(ym_abs);
				mul_b = MW'(ym_abs);
			end
			MUL_RX2T: begin
				mul_a = MW'(rx2_q);
				mul_b = t_q;
			end
			MUL_RX2RY2: begin
				mul_a = MW'(rx2_q);
				mul_b = MW'(ry2_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// One step of either region: slope updates and the new decision value.
	assign sx_inc   = sx_q + two_ry2;
	assign sy_dec   = sy_q - two_rx2;
	assign sx_inc_d = DW'(sx_inc);
	assign sy_dec_d = DW'(sy_dec);
	assign dec_neg  = dec_q[DW-1];
	assign dec_pos  = !dec_q[DW-1] && (dec_q != '0);
	assign dec_r1   = dec_q + ry2_s + sx_inc_d - (dec_neg ? DW'(0) : sy_dec_d);
	assign dec_r2   = dec_q + rx2_s - sy_dec_d + (dec_pos ? DW'(0) : sx_inc_d);

	// Curve state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			rx2_q    <= '0;
			ry2_q    <= '0;
			x_q      <= '0;
			y_q      <= '0;
			sx_q     <= '0;
			sy_q     <= '0;
			dec_q    <= '0;
			region_q <= REGION_DONE;
		end else begin
			if (cmd.capture) begin
				cx_q <= center_x;
				cy_q <= center_y;
			end
			case (cmd.act)
				ACT_RX2: rx2_q <= prod_q[SQW-1:0];
				ACT_RY2: ry2_q <= prod_q[SQW-1:0];
				ACT_INIT: begin
					x_q      <= '0;
					y_q      <= XW'(ry_q);
					sx_q     <= '0;
					sy_q     <= signed'({prod_q[SLW-2:0], 1'b0});
					dec_q    <= ry2_s - prod_s + rx2q_s;
					region_q <= REGION_ONE;
				end
				ACT_DEC_SW: begin
					dec_q    <= acc_q - prod_s;
					region_q <= REGION_TWO;
				end
				ACT_STEP: begin
					if (region_q == REGION_ONE) begin
						x_q   <= x_q + XW'(1);
						sx_q  <= sx_inc;
						dec_q <= dec_r1;
						if (!dec_neg) begin
							y_q  <= y_q - XW'(1);
							sy_q <= sy_dec;
						end
					end else begin
						y_q   <= y_q - XW'(1);
						sy_q  <= sy_dec;
						dec_q <= dec_r2;
						if (!dec_pos) begin
							x_q  <= x_q + XW'(1);
							sx_q <= sx_inc;
						end
					end
				end
				ACT_DONE: region_q <= REGION_DONE;
				default: ;
			endcase
		end
	end

	// Radii, product and scratch registers for the start computations.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rx_q <= radius_x;
			ry_q <= radius_y;
		end
		if (cmd.mul_sel != MUL_NONE) begin
			prod_q <= mul_p;
		end
		case (cmd.act)
			ACT_T_XX:     t_q   <= prod_q[MW-1:0] + MW'(x_q);
			ACT_T_PROD:   t_q   <= prod_q[MW-1:0];
			ACT_ACC_LOAD: acc_q <= prod_s + ry2q_s;
			ACT_ACC_ADD:  acc_q <= acc_q + prod_s;
			default: ;
		endcase
	end

	// Mirrored pixel selection: bit 0 negates x, bit 1 negates y.
	assign cx_w   = SUMW'(cx_q);
	assign cy_w   = SUMW'(cy_q);
	assign x_w    = signed'(SUMW'(x_q));
	assign y_w    = signed'(SUMW'(y_q));
	assign px_sel = cmd.out_idx[0] ? (cx_w - x_w) : (cx_w + x_w);
	assign py_sel = cmd.out_idx[1] ? (cy_w - y_w) : (cy_w + y_w);

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_fin) begin
				pixel_x_q <= '0;
				pixel_y_q <= '0;
				last_q    <= 1'b1;
				fin_q     <= 1'b1;
			end else begin
				pixel_x_q <= px_sel[PW-1:0];
				pixel_y_q <= py_sel[PW-1:0];
				last_q    <= (cmd.out_idx == LAST_PIXEL_IDX);
				fin_q     <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign last_of_run = last_q;
	assign finished    = fin_q;

	assign sts.region    = region_q;
	assign sts.sx_lt_sy  = (sx_q < sy_q);
	assign sts.y_nonzero = (y_q != '0);
	assign sts.out_free  = !out_valid_q || out_ready;

`ifndef SYNTH
	// The slope terms are twice a square times a coordinate and never go negative.
	assert property (@(posedge clk) disable iff (!arst_n)
		!sx_q[SLW-1] && !sy_q[SLW-1])
	else $error("slope term went negative");

	// A finished beat always closes its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fin_q |-> last_q)
	else $error("finished beat without last_of_run");

	// A region step only ever lowers y from a nonzero value in region two.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.act == ACT_STEP && region_q == REGION_TWO |-> y_q != '0)
	else $error("region two step with y at zero");
`endif

endmodule

[rtl/core/emr_ctrl.sv]
// Controller of the midpoint ellipse rasterizer: sequences the multiplier steps,
// the curve update and the four pixel beats. Depends on emr_pkg.
module emr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 op,
	output emr_pkg::emr_cmd_t    cmd,
	input  emr_pkg::emr_status_t sts
);
	import emr_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ST1,
		ST_ST2,
		ST_ST3,
		ST_ST4,
		ST_SW1,
		ST_SW2,
		ST_SW3,
		ST_SW4,
		ST_SW5,
		ST_SW6,
		ST_SW7,
		ST_SW8,
		ST_STEP,
		ST_EMIT,
		ST_FIN
	} state_t;

	state_t     state_q;
	logic [1:0] idx_q;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Command decode per state.
	always_comb begin
		cmd         = '0;
		cmd.mul_sel = MUL_NONE;
		cmd.act     = ACT_NONE;
		cmd.out_idx = idx_q;
		unique case (state_q)
			ST_IDLE: cmd.capture = accept && (op == OP_START);
			ST_ST1:  cmd.mul_sel = MUL_RXRX;
			ST_ST2: begin
				cmd.act     = ACT_RX2;
				cmd.mul_sel = MUL_RYRY;
			end
			ST_ST3: begin
				cmd.act     = ACT_RY2;
				cmd.mul_sel = MUL_RX2RY;
			end
			ST_ST4:  cmd.act = ACT_INIT;
			ST_SW1:  cmd.mul_sel = MUL_XX;
			ST_SW2:  cmd.act = ACT_T_XX;
			ST_SW3:  cmd.mul_sel = MUL_RY2T;
			ST_SW4: begin
				cmd.act     = ACT_ACC_LOAD;
				cmd.mul_sel = MUL_YMYM;
			end
			ST_SW5:  cmd.act = ACT_T_PROD;
			ST_SW6:  cmd.mul_sel = MUL_RX2T;
			ST_SW7: begin
				cmd.act     = ACT_ACC_ADD;
				cmd.mul_sel = MUL_RX2RY2;
			end
			ST_SW8:  cmd.act = ACT_DEC_SW;
			ST_STEP: cmd.act = ACT_STEP;
			ST_EMIT: cmd.out_load = sts.out_free;
			ST_FIN: begin
				cmd.out_load = sts.out_free;
				cmd.out_fin  = 1'b1;
				cmd.act      = sts.out_free ? ACT_DONE : ACT_NONE;
			end
			default: ;
		endcase
	end

	// State sequencing and the pixel beat counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (accept) begin
						if (op == OP_START) begin
							state_q <= ST_ST1;
						end else if (sts.region == REGION_ONE && !sts.sx_lt_sy) begin
							state_q <= ST_SW1;
						end else if (sts.region == REGION_ONE) begin
							state_q <= ST_STEP;
						end else if (sts.region == REGION_TWO && sts.y_nonzero) begin
							state_q <= ST_STEP;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_ST1:  state_q <= ST_ST2;
				ST_ST2:  state_q <= ST_ST3;
				ST_ST3:  state_q <= ST_ST4;
				ST_ST4:  state_q <= ST_EMIT;
				ST_SW1:  state_q <= ST_SW2;
				ST_SW2:  state_q <= ST_SW3;
				ST_SW3:  state_q <= ST_SW4;
				ST_SW4:  state_q <= ST_SW5;
				ST_SW5:  state_q <= ST_SW6;
				ST_SW6:  state_q <= ST_SW7;
				ST_SW7:  state_q <= ST_SW8;
				ST_SW8:  state_q <= sts.y_nonzero ? ST_STEP : ST_FIN;
				ST_STEP: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (sts.out_free) begin
						if (idx_q == LAST_PIXEL_IDX) begin
							state_q <= ST_IDLE;
						end
						idx_q <= idx_q + 2'd1;
					end
				end
				ST_FIN: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	// A result is never loaded over one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
	else $error("output register overwritten");

	// Once an item is taken, no other is taken in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
	else $error("second item accepted while busy");

	// A curve step is only issued while a curve is live.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_STEP |-> sts.region != REGION_DONE)
	else $error("step issued on a finished curve");
`endif

endmodule

[rtl/core/ellipse_midpoint_rasterizer.sv]
// Operation: a step item updates the curve, then emits 4 pixel beats at one per
// cycle through the single output register, stalled by back-pressure on the output;
// a start item first computes the squares and the region-one start on the shared
// multiplier; the step that enters region two first computes the region-two start
// on it; a finished step emits one finished beat. Reset (arst_n low, async)
// clears the curve to the finished state and empties the output register.
module ellipse_midpoint_rasterizer #(
	parameter int COORD_BITS  = emr_pkg::DEF_COORD_BITS,
	parameter int RADIUS_BITS = emr_pkg::DEF_RADIUS_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         op,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic [RADIUS_BITS-1:0]       radius_x,
	input  logic [RADIUS_BITS-1:0]       radius_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS:0]   pixel_x,
	output logic signed [COORD_BITS:0]   pixel_y,
	output logic                         last_of_run,
	output logic                         finished
);
	import emr_pkg::*;

	emr_cmd_t    cmd;
	emr_status_t sts;

	// Sequencer.
	emr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Curve arithmetic and output register.
	emr_datapath #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius_x    (radius_x),
		.radius_y    (radius_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.last_of_run (last_of_run),
		.finished    (finished)
	);

endmodule
